// ===== rtl/opg_pkg.sv =====
// ----------------------------------------------------------------------------
// opg_pkg
// Shared types, constants and arithmetic helpers of the orbit position
// generator: formats, cell counts, Horner divisor tables, Q2.30 rounding.
// ----------------------------------------------------------------------------
package opg_pkg;

  localparam int COORD_W   = 32;
  localparam int UNIT_BITS = 30;
  localparam int UNIT_W    = 32;
  localparam int VW        = 40;
  localparam int PW        = VW + UNIT_W;
  localparam int SQ_W      = 63;
  localparam int SQ_CELLS  = 32;
  localparam int DIV_W     = 31;
  localparam int DIV_CELLS = 31;
  localparam int SIDE_LEN  = SQ_CELLS + DIV_CELLS;
  localparam int HC_LAT    = 3;
  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  localparam int SIN_TAP   = SIN_STEPS * HC_LAT - 1;
  localparam int COS_TAP   = COS_STEPS * HC_LAT - 1;
  localparam int HEAD_LEN  = 5;
  localparam int TAIL_LEN  = 9;
  localparam int PIPE_LEN  = HEAD_LEN + SIDE_LEN + TAIL_LEN;
  localparam int RECIP_SHIFT = 34;
  localparam int HD_W      = 8;
  localparam int HR_W      = 34;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [16:0] U_ONE  = 17'd65536;

  localparam logic [HD_W-1:0] SIN_D [SIN_STEPS] = '{
    8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [HR_W-1:0] SIN_R [SIN_STEPS] = '{
    34'd110127366, 34'd156180628, 34'd238609294,
    34'd409044504, 34'd858993459, 34'd2863311530};
  localparam logic [HD_W-1:0] COS_D [COS_STEPS] = '{
    8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [HR_W-1:0] COS_R [COS_STEPS] = '{
    34'd94394885, 34'd130150524, 34'd190887435, 34'd306783378,
    34'd572662306, 34'd1431655765, 34'd8589934592};

  typedef enum logic [1:0] {
    ST_ORBIT    = 2'd0,
    ST_ENDPOINT = 2'd1,
    ST_ZERO_UP  = 2'd2,
    ST_ON_AXIS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct {
    logic signed [COORD_W-1:0] pos [3];
    logic signed [COORD_W-1:0] foc [3];
    logic signed [COORD_W-1:0] up [3];
    logic signed [7:0]         turns;
    logic [16:0]               prog;
    logic [COORD_W-1:0]        upm [3];
    logic [5:0]                blen;
    logic                      sgn [3];
    logic                      zero_up;
    logic                      endpoint;
    logic [15:0]               phase;
    logic [UNIT_BITS-1:0]      mn [3];
    logic [30:0]               x;
    logic [59:0]               sq [3];
    logic [61:0]               xx;
    logic [61:0]               ss;
    logic [31:0]               x2;
    logic [30:0]               sn;
    logic signed [UNIT_W-1:0]  c;
    logic signed [UNIT_W-1:0]  s;
    logic signed [UNIT_W-1:0]  ax [3];
    logic signed [VW-1:0]      off [3];
    logic signed [VW-1:0]      term [3];
    logic signed [VW-1:0]      h;
    logic signed [VW-1:0]      hax [3];
    logic signed [VW-1:0]      e1 [3];
    logic                      below;
    logic [31:0]               esq [3];
    logic signed [VW-1:0]      xp [6];
    logic signed [VW-1:0]      ce [3];
    logic signed [VW-1:0]      cr [3];
    logic signed [VW-1:0]      sc [3];
    logic [1:0]                status;
    logic signed [COORD_W-1:0] res [3];
  } work_t;

  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } out_t;

  function automatic logic [5:0] bit_len(input logic [COORD_W-1:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < COORD_W; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  function automatic logic signed [VW-1:0] round_q30(input logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = p[PW-1] ? PW'(-p) : PW'(p);
    r = (m + (PW'(1) << (UNIT_BITS - 1))) >> UNIT_BITS;
    return p[PW-1] ? -$signed(r[VW-1:0]) : $signed(r[VW-1:0]);
  endfunction

  function automatic logic signed [VW-1:0] mul_q30(input logic signed [VW-1:0] a,
                                                  input logic signed [UNIT_W-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return round_q30(p);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] lo;
    hi = VW'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - VW'(1);
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/opg_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// opg_sqrt_cell
// One digit of the integer square root: try res + bit, keep the remainder.
// ----------------------------------------------------------------------------
module opg_sqrt_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [opg_pkg::SQ_W-1:0] n_i,
  input  logic [opg_pkg::SQ_W-1:0] res_i,
  input  logic [4:0]               lvl_i,
  output logic [opg_pkg::SQ_W-1:0] n_o,
  output logic [opg_pkg::SQ_W-1:0] res_o,
  output logic [4:0]               lvl_o
);

  logic [opg_pkg::SQ_W-1:0] bitv;
  logic [opg_pkg::SQ_W:0]   trial;
  logic                     take;

  always_comb begin
    bitv  = opg_pkg::SQ_W'(1) << {lvl_i, 1'b0};
    trial = {1'b0, res_i} + {1'b0, bitv};
    take  = {1'b0, n_i} >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_o   <= take ? opg_pkg::SQ_W'({1'b0, n_i} - trial) : n_i;
      res_o <= take ? (res_i >> 1) + bitv : res_i >> 1;
      lvl_o <= lvl_i - 5'd1;
    end
  end

endmodule

// ===== rtl/opg_div_cell.sv =====
// ----------------------------------------------------------------------------
// opg_div_cell
// One quotient bit of a restoring divider: shift in a dividend bit, subtract.
// ----------------------------------------------------------------------------
module opg_div_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [opg_pkg::DIV_W-1:0] rem_i,
  input  logic [opg_pkg::DIV_W-1:0] num_i,
  input  logic [opg_pkg::DIV_W-1:0] q_i,
  input  logic [opg_pkg::DIV_W-1:0] d_i,
  output logic [opg_pkg::DIV_W-1:0] rem_o,
  output logic [opg_pkg::DIV_W-1:0] num_o,
  output logic [opg_pkg::DIV_W-1:0] q_o,
  output logic [opg_pkg::DIV_W-1:0] d_o
);

  logic [opg_pkg::DIV_W:0] trial;
  logic [opg_pkg::DIV_W:0] diff;
  logic                    ge;

  always_comb begin
    trial = {rem_i, num_i[opg_pkg::DIV_W-1]};
    diff  = trial - {1'b0, d_i};
    ge    = trial >= {1'b0, d_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[opg_pkg::DIV_W-1:0] : trial[opg_pkg::DIV_W-1:0];
      num_o <= num_i << 1;
      q_o   <= {q_i[opg_pkg::DIV_W-2:0], ge};
      d_o   <= d_i;
    end
  end

endmodule

// ===== rtl/opg_horner_cell.sv =====
// ----------------------------------------------------------------------------
// opg_horner_cell
// One Horner step of the sine or cosine series: t = 1 - round(x2*t)/d,
// clamped at zero, over three register stages.
// ----------------------------------------------------------------------------
module opg_horner_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              x2_i,
  input  logic [30:0]              t_i,
  input  logic [opg_pkg::HD_W-1:0] d_i,
  input  logic [opg_pkg::HR_W-1:0] r_i,
  output logic [31:0]              x2_o,
  output logic [30:0]              t_o
);

  logic [62:0] prod_a;
  logic [31:0] x2_a;
  logic [32:0] n_b_next;
  logic [66:0] recip_b;
  logic [32:0] n_b;
  logic [31:0] x2_b;
  logic [32:0] qe;
  logic [32:0] rem;
  logic [32:0] q;

  always_comb begin
    n_b_next = 33'((prod_a + (63'(1) << (opg_pkg::UNIT_BITS - 1))) >> opg_pkg::UNIT_BITS)
             + 33'(d_i >> 1);
    qe  = 33'(recip_b >> opg_pkg::RECIP_SHIFT);
    rem = n_b - qe * 33'(d_i);
    q   = (rem >= 33'(d_i)) ? qe + 33'd1 : qe;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a  <= 63'(x2_i) * 63'(t_i);
      x2_a    <= x2_i;
      n_b     <= n_b_next;
      recip_b <= 67'(n_b_next) * 67'(r_i);
      x2_b    <= x2_a;
      x2_o    <= x2_b;
      t_o     <= (q > (33'd1 << opg_pkg::UNIT_BITS)) ? 31'd0
                 : 31'((33'd1 << opg_pkg::UNIT_BITS) - q);
    end
  end

endmodule

// ===== rtl/orbit_position_generator_unit.sv =====
// ----------------------------------------------------------------------------
// orbit_position_generator_unit
// Swings a camera position about its normalized view-up axis through the
// focal point by turns*u full circles. Fully pipelined: one beat is taken
// every cycle unless the output queue is full. The depth is set by a 32-cell
// square root chain and a 31-cell divider chain (three lanes) that normalize
// the up vector, after five head stages and followed by nine stages of Q2.30
// products; the sine and cosine Horner chains run alongside. A two-entry
// output queue takes up stalls on the result side; in_ready drops only while
// it is full.
// min_radius may be rewritten only while no beat is in flight.
// ----------------------------------------------------------------------------
module orbit_position_generator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [15:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [opg_pkg::COORD_W-1:0] pos_x,
  input  logic signed [opg_pkg::COORD_W-1:0] pos_y,
  input  logic signed [opg_pkg::COORD_W-1:0] pos_z,
  input  logic signed [opg_pkg::COORD_W-1:0] focus_x,
  input  logic signed [opg_pkg::COORD_W-1:0] focus_y,
  input  logic signed [opg_pkg::COORD_W-1:0] focus_z,
  input  logic signed [opg_pkg::COORD_W-1:0] up_x,
  input  logic signed [opg_pkg::COORD_W-1:0] up_y,
  input  logic signed [opg_pkg::COORD_W-1:0] up_z,
  input  logic signed [7:0]                  turns,
  input  logic [16:0]                        progress,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [opg_pkg::COORD_W-1:0] out_x,
  output logic signed [opg_pkg::COORD_W-1:0] out_y,
  output logic signed [opg_pkg::COORD_W-1:0] out_z,
  output logic [1:0]                         status
);

  logic [15:0] min_radius;
  logic [31:0] min_radius_sq;
  logic        en;
  logic [opg_pkg::PIPE_LEN-1:0] vpipe;

  opg_pkg::work_t w_in, s1, s2, s3, s4, s5;
  opg_pkg::work_t s2_next, s3_next, s4_next, s5_next;
  opg_pkg::work_t side [opg_pkg::SIDE_LEN];
  opg_pkg::work_t side_next [opg_pkg::SIDE_LEN];
  opg_pkg::work_t t1, t2, t3, t4, t5, t6, t7, t8, t9;
  opg_pkg::work_t t1_next, t2_next, t3_next, t4_next, t5_next;
  opg_pkg::work_t t6_next, t7_next, t8_next, t9_next;

  logic [opg_pkg::SQ_W-1:0] sq_n   [opg_pkg::SQ_CELLS+1];
  logic [opg_pkg::SQ_W-1:0] sq_res [opg_pkg::SQ_CELLS+1];
  logic [4:0]               sq_lvl [opg_pkg::SQ_CELLS+1];

  logic [opg_pkg::DIV_W-1:0] dv_rem [3][opg_pkg::DIV_CELLS+1];
  logic [opg_pkg::DIV_W-1:0] dv_num [3][opg_pkg::DIV_CELLS+1];
  logic [opg_pkg::DIV_W-1:0] dv_q   [3][opg_pkg::DIV_CELLS+1];
  logic [opg_pkg::DIV_W-1:0] dv_d   [3][opg_pkg::DIV_CELLS+1];
  logic [opg_pkg::DIV_W-1:0] len_fix;
  logic [60:0]               dv_numer [3];

  logic [31:0] sin_x2 [opg_pkg::SIN_STEPS+1];
  logic [30:0] sin_t  [opg_pkg::SIN_STEPS+1];
  logic [31:0] cos_x2 [opg_pkg::COS_STEPS+1];
  logic [30:0] cos_t  [opg_pkg::COS_STEPS+1];

  opg_pkg::out_t fifo [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_radius    <= 16'd1;
      min_radius_sq <= 32'd1;
    end else if (cfg_we) begin
      min_radius    <= cfg_data;
      min_radius_sq <= 32'(cfg_data) * 32'(cfg_data);
    end
  end

  assign en       = (count != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[opg_pkg::PIPE_LEN-2:0], in_valid};
    end
  end

  // head stages
  always_comb begin
    w_in = '{default: '0};
    w_in.pos[0] = pos_x;   w_in.pos[1] = pos_y;   w_in.pos[2] = pos_z;
    w_in.foc[0] = focus_x; w_in.foc[1] = focus_y; w_in.foc[2] = focus_z;
    w_in.up[0]  = up_x;    w_in.up[1]  = up_y;    w_in.up[2]  = up_z;
    w_in.turns  = turns;
    w_in.prog   = progress;
  end

  always_comb begin
    logic [opg_pkg::COORD_W-1:0] top;
    logic [16:0]                 u;
    logic signed [25:0]          ph;
    s2_next = s1;
    top = '0;
    for (int k = 0; k < 3; k++) begin
      s2_next.upm[k] = s1.up[k][opg_pkg::COORD_W-1] ? opg_pkg::COORD_W'(-s1.up[k])
                                                     : opg_pkg::COORD_W'(s1.up[k]);
      s2_next.sgn[k] = s1.up[k][opg_pkg::COORD_W-1];
      s2_next.off[k] = opg_pkg::VW'(s1.pos[k]) - opg_pkg::VW'(s1.foc[k]);
      if (s2_next.upm[k] > top) top = s2_next.upm[k];
    end
    s2_next.blen    = opg_pkg::bit_len(top);
    s2_next.zero_up = (top == '0);
    u = (s1.prog > opg_pkg::U_ONE) ? opg_pkg::U_ONE : s1.prog;
    s2_next.endpoint = (u == 17'd0) || (u == opg_pkg::U_ONE);
    ph = s1.turns * $signed({1'b0, u});
    s2_next.phase = ph[15:0];
  end

  always_comb begin
    logic [61:0] sh;
    logic [45:0] xprod;
    s3_next = s2;
    for (int k = 0; k < 3; k++) begin
      if (s2.blen > 6'd30) sh = 62'(s2.upm[k] >> (s2.blen - 6'd30));
      else sh = 62'(s2.upm[k]) << (6'd30 - s2.blen);
      s3_next.mn[k] = sh[opg_pkg::UNIT_BITS-1:0];
    end
    xprod = 46'(s2.phase[13:0]) * 46'(opg_pkg::PI_Q30);
    s3_next.x = 31'((xprod + (46'(1) << 14)) >> 15);
  end

  always_comb begin
    s4_next = s3;
    for (int k = 0; k < 3; k++) s4_next.sq[k] = 60'(s3.mn[k]) * 60'(s3.mn[k]);
    s4_next.xx = 62'(s3.x) * 62'(s3.x);
  end

  always_comb begin
    s5_next = s4;
    s5_next.ss = 62'(s4.sq[0]) + 62'(s4.sq[1]) + 62'(s4.sq[2]);
    s5_next.x2 = 32'((s4.xx + (62'(1) << (opg_pkg::UNIT_BITS - 1))) >> opg_pkg::UNIT_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= w_in;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
    end
  end

  // square root chain
  assign sq_n[0]   = opg_pkg::SQ_W'(s5.ss);
  assign sq_res[0] = '0;
  assign sq_lvl[0] = 5'd31;

  for (genvar i = 0; i < opg_pkg::SQ_CELLS; i++) begin : g_sqrt
    opg_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .n_i   (sq_n[i]),
      .res_i (sq_res[i]),
      .lvl_i (sq_lvl[i]),
      .n_o   (sq_n[i+1]),
      .res_o (sq_res[i+1]),
      .lvl_o (sq_lvl[i+1])
    );
  end

  // divider chains, one lane per axis component
  assign len_fix = (sq_res[opg_pkg::SQ_CELLS][opg_pkg::DIV_W-1:0] == '0) ? opg_pkg::DIV_W'(1)
                 : sq_res[opg_pkg::SQ_CELLS][opg_pkg::DIV_W-1:0];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign dv_numer[k] = {1'b0, side[opg_pkg::SQ_CELLS-1].mn[k], 30'd0}
                       + 61'(len_fix >> 1);
    assign dv_rem[k][0] = {1'b0, dv_numer[k][60:31]};
    assign dv_num[k][0] = dv_numer[k][30:0];
    assign dv_q[k][0]   = '0;
    assign dv_d[k][0]   = len_fix;
    for (genvar j = 0; j < opg_pkg::DIV_CELLS; j++) begin : g_div
      opg_div_cell u_cell (
        .clk   (clk),
        .en    (en),
        .rem_i (dv_rem[k][j]),
        .num_i (dv_num[k][j]),
        .q_i   (dv_q[k][j]),
        .d_i   (dv_d[k][j]),
        .rem_o (dv_rem[k][j+1]),
        .num_o (dv_num[k][j+1]),
        .q_o   (dv_q[k][j+1]),
        .d_o   (dv_d[k][j+1])
      );
    end
  end

  // sine and cosine series
  assign sin_x2[0] = s5.x2;
  assign sin_t[0]  = 31'(33'd1 << opg_pkg::UNIT_BITS);
  assign cos_x2[0] = s5.x2;
  assign cos_t[0]  = 31'(33'd1 << opg_pkg::UNIT_BITS);

  for (genvar i = 0; i < opg_pkg::SIN_STEPS; i++) begin : g_sin
    opg_horner_cell u_cell (
      .clk  (clk),
      .en   (en),
      .x2_i (sin_x2[i]),
      .t_i  (sin_t[i]),
      .d_i  (opg_pkg::SIN_D[i]),
      .r_i  (opg_pkg::SIN_R[i]),
      .x2_o (sin_x2[i+1]),
      .t_o  (sin_t[i+1])
    );
  end

  for (genvar i = 0; i < opg_pkg::COS_STEPS; i++) begin : g_cos
    opg_horner_cell u_cell (
      .clk  (clk),
      .en   (en),
      .x2_i (cos_x2[i]),
      .t_i  (cos_t[i]),
      .d_i  (opg_pkg::COS_D[i]),
      .r_i  (opg_pkg::COS_R[i]),
      .x2_o (cos_x2[i+1]),
      .t_o  (cos_t[i+1])
    );
  end

  // side line alongside the chains
  always_comb begin
    logic signed [opg_pkg::UNIT_W-1:0] cs;
    logic signed [opg_pkg::UNIT_W-1:0] sn;
    side_next[0] = s5;
    for (int i = 1; i < opg_pkg::SIDE_LEN; i++) side_next[i] = side[i-1];
    side_next[opg_pkg::SIN_TAP+1].sn =
      31'((62'(side[opg_pkg::SIN_TAP].x) * 62'(sin_t[opg_pkg::SIN_STEPS])
           + (62'(1) << (opg_pkg::UNIT_BITS - 1))) >> opg_pkg::UNIT_BITS);
    cs = $signed({1'b0, cos_t[opg_pkg::COS_STEPS]});
    sn = $signed({1'b0, side[opg_pkg::COS_TAP].sn});
    case (opg_pkg::quad_t'(side[opg_pkg::COS_TAP].phase[15:14]))
      opg_pkg::QUAD_0: begin
        side_next[opg_pkg::COS_TAP+1].c = cs;
        side_next[opg_pkg::COS_TAP+1].s = sn;
      end
      opg_pkg::QUAD_1: begin
        side_next[opg_pkg::COS_TAP+1].c = -sn;
        side_next[opg_pkg::COS_TAP+1].s = cs;
      end
      opg_pkg::QUAD_2: begin
        side_next[opg_pkg::COS_TAP+1].c = -cs;
        side_next[opg_pkg::COS_TAP+1].s = -sn;
      end
      default: begin
        side_next[opg_pkg::COS_TAP+1].c = sn;
        side_next[opg_pkg::COS_TAP+1].s = -cs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < opg_pkg::SIDE_LEN; i++) side[i] <= side_next[i];
    end
  end

  // tail stages
  always_comb begin
    t1_next = side[opg_pkg::SIDE_LEN-1];
    for (int k = 0; k < 3; k++) begin
      t1_next.ax[k] = side[opg_pkg::SIDE_LEN-1].sgn[k]
                    ? -$signed({1'b0, dv_q[k][opg_pkg::DIV_CELLS]})
                    : $signed({1'b0, dv_q[k][opg_pkg::DIV_CELLS]});
    end
  end

  always_comb begin
    t2_next = t1;
    for (int k = 0; k < 3; k++) t2_next.term[k] = opg_pkg::mul_q30(t1.off[k], t1.ax[k]);
  end

  always_comb begin
    t3_next = t2;
    t3_next.h = t2.term[0] + t2.term[1] + t2.term[2];
  end

  always_comb begin
    t4_next = t3;
    for (int k = 0; k < 3; k++) t4_next.hax[k] = opg_pkg::mul_q30(t3.h, t3.ax[k]);
  end

  always_comb begin
    t5_next = t4;
    for (int k = 0; k < 3; k++) t5_next.e1[k] = t4.off[k] - t4.hax[k];
  end

  always_comb begin
    logic [opg_pkg::VW-1:0] em;
    t6_next = t5;
    t6_next.below = 1'b1;
    for (int k = 0; k < 3; k++) begin
      em = t5.e1[k][opg_pkg::VW-1] ? opg_pkg::VW'(-t5.e1[k]) : opg_pkg::VW'(t5.e1[k]);
      if (em >= opg_pkg::VW'(min_radius)) t6_next.below = 1'b0;
      t6_next.esq[k] = 32'(em[15:0]) * 32'(em[15:0]);
      t6_next.ce[k]  = opg_pkg::mul_q30(t5.e1[k], t5.c);
    end
    t6_next.xp[0] = opg_pkg::mul_q30(t5.e1[2], t5.ax[1]);
    t6_next.xp[1] = opg_pkg::mul_q30(t5.e1[1], t5.ax[2]);
    t6_next.xp[2] = opg_pkg::mul_q30(t5.e1[0], t5.ax[2]);
    t6_next.xp[3] = opg_pkg::mul_q30(t5.e1[2], t5.ax[0]);
    t6_next.xp[4] = opg_pkg::mul_q30(t5.e1[1], t5.ax[0]);
    t6_next.xp[5] = opg_pkg::mul_q30(t5.e1[0], t5.ax[1]);
  end

  always_comb begin
    logic [33:0] ssum;
    t7_next = t6;
    ssum = 34'(t6.esq[0]) + 34'(t6.esq[1]) + 34'(t6.esq[2]);
    if (t6.zero_up) t7_next.status = opg_pkg::ST_ZERO_UP;
    else if (t6.below && (ssum < 34'(min_radius_sq))) t7_next.status = opg_pkg::ST_ON_AXIS;
    else if (t6.endpoint) t7_next.status = opg_pkg::ST_ENDPOINT;
    else t7_next.status = opg_pkg::ST_ORBIT;
    t7_next.cr[0] = t6.xp[0] - t6.xp[1];
    t7_next.cr[1] = t6.xp[2] - t6.xp[3];
    t7_next.cr[2] = t6.xp[4] - t6.xp[5];
  end

  always_comb begin
    t8_next = t7;
    for (int k = 0; k < 3; k++) t8_next.sc[k] = opg_pkg::mul_q30(t7.cr[k], t7.s);
  end

  always_comb begin
    t9_next = t8;
    for (int k = 0; k < 3; k++) begin
      t9_next.res[k] = (t8.status != opg_pkg::ST_ORBIT) ? t8.pos[k]
                     : opg_pkg::sat_coord(opg_pkg::VW'(t8.foc[k]) + t8.hax[k]
                                          + t8.ce[k] + t8.sc[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= t1_next;
      t2 <= t2_next;
      t3 <= t3_next;
      t4 <= t4_next;
      t5 <= t5_next;
      t6 <= t6_next;
      t7 <= t7_next;
      t8 <= t8_next;
      t9 <= t9_next;
    end
  end

  // output queue
  assign push = en && vpipe[opg_pkg::PIPE_LEN-1];
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{status: opg_pkg::status_t'(t9.status),
                        z: t9.res[2], y: t9.res[1], x: t9.res[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid = (count != 2'd0);
  assign out_x     = fifo[rd_ptr].x;
  assign out_y     = fifo[rd_ptr].y;
  assign out_z     = fifo[rd_ptr].z;
  assign status    = fifo[rd_ptr].status;

endmodule

// ===== rtl/opg_checker.sv =====
// ----------------------------------------------------------------------------
// opg_checker
// Port-level checks of the orbit position generator, bound to the top level.
// ----------------------------------------------------------------------------
module opg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_we,
  input logic [15:0]                        cfg_data,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [opg_pkg::COORD_W-1:0] pos_x,
  input logic signed [opg_pkg::COORD_W-1:0] pos_y,
  input logic signed [opg_pkg::COORD_W-1:0] pos_z,
  input logic signed [opg_pkg::COORD_W-1:0] focus_x,
  input logic signed [opg_pkg::COORD_W-1:0] focus_y,
  input logic signed [opg_pkg::COORD_W-1:0] focus_z,
  input logic signed [opg_pkg::COORD_W-1:0] up_x,
  input logic signed [opg_pkg::COORD_W-1:0] up_y,
  input logic signed [opg_pkg::COORD_W-1:0] up_z,
  input logic signed [7:0]                  turns,
  input logic [16:0]                        progress,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [opg_pkg::COORD_W-1:0] out_x,
  input logic signed [opg_pkg::COORD_W-1:0] out_y,
  input logic signed [opg_pkg::COORD_W-1:0] out_z,
  input logic [1:0]                         status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                               && $stable(out_z) && $stable(status))
    else $error("result beat changed while stalled");

  a_full_valid: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked with no result waiting");

  a_block_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input blocked without a result stall");

endmodule

bind orbit_position_generator_unit opg_checker u_opg_checker (.*);
